>>> hdl/mms_pkg.sv
`timescale 1ns / 1ps

package mms_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_START = 4'd1,
      PH_OP0   = 4'd2,
      PH_OP1   = 4'd3,
      PH_ADDR  = 4'd4,
      PH_TURN1 = 4'd5,
      PH_TURN2 = 4'd6,
      PH_READ  = 4'd7,
      PH_WRITE = 4'd8
   } phase_type;

   localparam logic [1:0] OPC_WRITE = 2'b01;
   localparam logic [1:0] OPC_READ  = 2'b10;

   // address phase ends once the counter has reached this value
   localparam logic [3:0] ADDR_LAST = 4'd10;
   // data bits go msb first
   localparam logic [3:0] DATA_MSB  = 4'd15;

   typedef struct packed {
      logic        last_clock;
      logic        drive_level;
      phase_type   phase;
      logic [1:0]  op_bits;
      logic [3:0]  bit_index;
      logic [9:0]  address_shift;
      logic [15:0] data_word;
   } frame_state_type;

   typedef struct packed {
      logic        data_in_pin;
      logic [4:0]  phy_address;
      logic [4:0]  reg_address;
      logic        read_strobe;
      logic        write_strobe;
      logic [15:0] write_value;
      logic        bad_opcode;
   } result_type;

endpackage

>>> hdl/mms_req_if.sv
`timescale 1ns / 1ps

interface mms_req_if;
   logic        valid;
   logic        ready;
   logic        clock_pin;
   logic        data_out_pin;
   logic [15:0] read_data;

   modport source (output valid, output clock_pin, output data_out_pin, output read_data,
                   input ready);
   modport sink (input valid, input clock_pin, input data_out_pin, input read_data,
                 output ready);
endinterface

>>> hdl/mms_rsp_if.sv
`timescale 1ns / 1ps

interface mms_rsp_if;
   logic        valid;
   logic        ready;
   logic        data_in_pin;
   logic [4:0]  phy_address;
   logic [4:0]  reg_address;
   logic        read_strobe;
   logic        write_strobe;
   logic [15:0] write_value;
   logic        bad_opcode;

   modport source (output valid, output data_in_pin, output phy_address,
                   output reg_address, output read_strobe, output write_strobe,
                   output write_value, output bad_opcode, input ready);
   modport sink (input valid, input data_in_pin, input phy_address,
                 input reg_address, input read_strobe, input write_strobe,
                 input write_value, input bad_opcode, output ready);
endinterface

>>> hdl/mdio_management_slave.sv
`timescale 1ns / 1ps
// result: registered, shown on rsp in the cycle after its pin sample is transferred
// throughput: one sample per cycle; a new sample is taken while the last result
// waits, as long as the result register is empty or being emptied that cycle
// reset: synchronous, active high; frame engine goes idle with clock and
// data-in levels high, address and data words cleared, no result pending

module mdio_management_slave (
   input logic    clock,
   input logic    reset,
   mms_req_if.sink   req_if,
   mms_rsp_if.source rsp_if
);
   import mms_pkg::*;

   frame_state_type state_ff;
   frame_state_type state_in;
   result_type      result_ff;
   result_type      result_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            req_transfer;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_transfer = req_if.valid && req_if.ready;

   mms_frame_engine u_engine (
      .state_cur    (state_ff),
      .clock_pin    (req_if.clock_pin),
      .data_out_pin (req_if.data_out_pin),
      .read_data    (req_if.read_data),
      .state_nxt    (state_in),
      .result       (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_clock    <= 1'b1;
         state_ff.drive_level   <= 1'b1;
         state_ff.phase         <= PH_IDLE;
         state_ff.op_bits       <= '0;
         state_ff.bit_index     <= '0;
         state_ff.address_shift <= '0;
         state_ff.data_word     <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (req_transfer) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.data_in_pin  = result_ff.data_in_pin;
   assign rsp_if.phy_address  = result_ff.phy_address;
   assign rsp_if.reg_address  = result_ff.reg_address;
   assign rsp_if.read_strobe  = result_ff.read_strobe;
   assign rsp_if.write_strobe = result_ff.write_strobe;
   assign rsp_if.write_value  = result_ff.write_value;
   assign rsp_if.bad_opcode   = result_ff.bad_opcode;

endmodule

>>> hdl/mms_frame_engine.sv
`timescale 1ns / 1ps

module mms_frame_engine (
   input  mms_pkg::frame_state_type state_cur,
   input  logic                     clock_pin,
   input  logic                     data_out_pin,
   input  logic [15:0]              read_data,
   output mms_pkg::frame_state_type state_nxt,
   output mms_pkg::result_type      result
);
   import mms_pkg::*;

   logic       rising;
   logic [1:0] op_full;
   logic       rstb;
   logic       wstb;
   logic       bad;

   assign rising  = !state_cur.last_clock && clock_pin;
   assign op_full = state_cur.op_bits | {1'b0, data_out_pin};

   always_comb begin
      state_nxt            = state_cur;
      state_nxt.last_clock = clock_pin;
      rstb                 = 1'b0;
      wstb                 = 1'b0;
      bad                  = 1'b0;
      if (rising) begin
         case (state_cur.phase)
            PH_IDLE: begin
               // no preamble check: any low level starts a frame
               state_nxt.phase = data_out_pin ? PH_IDLE : PH_START;
            end
            PH_START: begin
               state_nxt.phase = data_out_pin ? PH_OP0 : PH_IDLE;
            end
            PH_OP0: begin
               state_nxt.op_bits = {data_out_pin, 1'b0};
               state_nxt.phase   = PH_OP1;
            end
            PH_OP1: begin
               state_nxt.op_bits       = op_full;
               state_nxt.bit_index     = '0;
               state_nxt.address_shift = '0;
               if (op_full == OPC_READ || op_full == OPC_WRITE) begin
                  state_nxt.phase = PH_ADDR;
               end else begin
                  bad             = 1'b1;
                  state_nxt.phase = PH_IDLE;
               end
            end
            PH_ADDR: begin
               state_nxt.address_shift = {state_cur.address_shift[8:0], data_out_pin};
               state_nxt.bit_index     = state_cur.bit_index + 4'd1;
               // the incremented count reaching the limit ends the address field
               if (state_cur.bit_index == ADDR_LAST - 4'd1) begin
                  state_nxt.phase = PH_TURN1;
               end
            end
            PH_TURN1: begin
               state_nxt.phase = PH_TURN2;
            end
            PH_TURN2: begin
               state_nxt.bit_index = DATA_MSB;
               if (state_cur.op_bits == OPC_READ) begin
                  state_nxt.data_word = read_data;
                  rstb                = 1'b1;
                  state_nxt.phase     = PH_READ;
               end else begin
                  state_nxt.data_word = '0;
                  state_nxt.phase     = PH_WRITE;
               end
            end
            PH_READ: begin
               state_nxt.drive_level = state_cur.data_word[state_cur.bit_index];
               if (state_cur.bit_index == 4'd0) begin
                  state_nxt.phase = PH_IDLE;
               end else begin
                  state_nxt.bit_index = state_cur.bit_index - 4'd1;
               end
            end
            PH_WRITE: begin
               // echo the master's bit back on data-in
               state_nxt.drive_level = data_out_pin;
               if (data_out_pin) begin
                  state_nxt.data_word[state_cur.bit_index] = 1'b1;
               end
               if (state_cur.bit_index == 4'd0) begin
                  wstb            = 1'b1;
                  state_nxt.phase = PH_IDLE;
               end else begin
                  state_nxt.bit_index = state_cur.bit_index - 4'd1;
               end
            end
            default: begin
               state_nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      result.data_in_pin  = state_nxt.drive_level;
      result.phy_address  = state_nxt.address_shift[9:5];
      result.reg_address  = state_nxt.address_shift[4:0];
      result.read_strobe  = rstb;
      result.write_strobe = wstb;
      result.write_value  = state_nxt.data_word;
      result.bad_opcode   = bad;
   end

endmodule

>>> tb/mdio_management_slave_tb.sv
`timescale 1ns / 1ps

module mdio_management_slave_tb;
   import mms_pkg::*;

   localparam int SAMPLE_TARGET = 1400;
   localparam int MAX_WAIT      = 18;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_AFTER    = 300;
   localparam int RESYNC_BITS   = 32;
   localparam int FRAME_BITS    = 32;

   localparam logic [1:0] START_BITS = 2'b01;
   // opcodes that are neither read nor write
   localparam logic [1:0] OPC_ZERO   = 2'b00;
   localparam logic [1:0] OPC_ONES   = 2'b11;

   class mdio_frame_scoreboard;
      frame_state_type frame;
      result_type      pending_results[$];
      int unsigned     mismatch_count;
      int unsigned     checked_count;

      function new();
         frame = '0;
         frame.last_clock  = 1'b1;
         frame.drive_level = 1'b1;
         frame.phase       = PH_IDLE;
         mismatch_count    = 0;
         checked_count     = 0;
      endfunction

      function result_type advance_frame(logic clk, logic mdo, logic [15:0] rd);
         result_type r;
         logic       rising;
         r = '0;
         rising = !frame.last_clock && clk;
         frame.last_clock = clk;
         if (rising) begin
            case (frame.phase)
               PH_IDLE: begin
                  if (!mdo) frame.phase = PH_START;
               end
               PH_START: begin
                  if (mdo) frame.phase = PH_OP0;
                  else frame.phase = PH_IDLE;
               end
               PH_OP0: begin
                  frame.op_bits = {mdo, 1'b0};
                  frame.phase   = PH_OP1;
               end
               PH_OP1: begin
                  frame.op_bits       = frame.op_bits | {1'b0, mdo};
                  frame.bit_index     = '0;
                  frame.address_shift = '0;
                  if (frame.op_bits == OPC_READ || frame.op_bits == OPC_WRITE) begin
                     frame.phase = PH_ADDR;
                  end else begin
                     r.bad_opcode = 1'b1;
                     frame.phase  = PH_IDLE;
                  end
               end
               PH_ADDR: begin
                  frame.address_shift = {frame.address_shift[8:0], mdo};
                  frame.bit_index     = frame.bit_index + 4'd1;
                  if (frame.bit_index == ADDR_LAST) frame.phase = PH_TURN1;
               end
               PH_TURN1: begin
                  frame.phase = PH_TURN2;
               end
               PH_TURN2: begin
                  frame.bit_index = DATA_MSB;
                  if (frame.op_bits == OPC_READ) begin
                     frame.data_word = rd;
                     r.read_strobe   = 1'b1;
                     frame.phase     = PH_READ;
                  end else begin
                     // write data starts from zero before bits are collected
                     frame.data_word = '0;
                     frame.phase     = PH_WRITE;
                  end
               end
               PH_READ: begin
                  frame.drive_level = frame.data_word[frame.bit_index];
                  if (frame.bit_index == 4'd0) frame.phase = PH_IDLE;
                  else frame.bit_index = frame.bit_index - 4'd1;
               end
               PH_WRITE: begin
                  frame.drive_level = mdo;
                  if (mdo) frame.data_word[frame.bit_index] = 1'b1;
                  if (frame.bit_index == 4'd0) begin
                     r.write_strobe = 1'b1;
                     frame.phase    = PH_IDLE;
                  end else begin
                     frame.bit_index = frame.bit_index - 4'd1;
                  end
               end
               default: begin
                  frame.phase = PH_IDLE;
               end
            endcase
         end
         r.data_in_pin = frame.drive_level;
         r.phy_address = frame.address_shift[9:5];
         r.reg_address = frame.address_shift[4:0];
         r.write_value = frame.data_word;
         return r;
      endfunction

      function void note_sample(logic clk, logic mdo, logic [15:0] rd);
         pending_results.push_back(advance_frame(clk, mdo, rd));
      endfunction

      function void note_mismatch(string what, int unsigned want_v, int unsigned got_v);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: expected %0h, actual %0h",
                     what, $realtime, want_v, got_v);
      endfunction

      function void check_result(result_type got);
         result_type want;
         checked_count++;
         if (pending_results.size() == 0) begin
            note_mismatch("transfer with nothing pending", 32'd0, 32'(got));
            return;
         end
         want = pending_results.pop_front();
         if (got.data_in_pin !== want.data_in_pin)
            note_mismatch("data_in_pin", 32'(want.data_in_pin), 32'(got.data_in_pin));
         if (got.phy_address !== want.phy_address)
            note_mismatch("phy_address", 32'(want.phy_address), 32'(got.phy_address));
         if (got.reg_address !== want.reg_address)
            note_mismatch("reg_address", 32'(want.reg_address), 32'(got.reg_address));
         if (got.read_strobe !== want.read_strobe)
            note_mismatch("read_strobe", 32'(want.read_strobe), 32'(got.read_strobe));
         if (got.write_strobe !== want.write_strobe)
            note_mismatch("write_strobe", 32'(want.write_strobe), 32'(got.write_strobe));
         if (got.write_value !== want.write_value)
            note_mismatch("write_value", 32'(want.write_value), 32'(got.write_value));
         if (got.bad_opcode !== want.bad_opcode)
            note_mismatch("bad_opcode", 32'(want.bad_opcode), 32'(got.bad_opcode));
      endfunction
   endclass

   logic clock;
   logic reset;

   mms_req_if req ();
   mms_rsp_if rsp ();

   mdio_management_slave uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   mdio_frame_scoreboard board = new();
   int unsigned sent_count  = 0;
   bit          hold_active = 1'b0;
   bit          hold_done   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

   // both sides run without gaps through this window
   function automatic int draw_wait();
      if (sent_count >= 700 && sent_count < 900) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic send_sample(input logic clk, input logic mdo, input logic [15:0] rd);
      int gap;
      gap = hold_active ? 0 : draw_wait();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.clock_pin    <= clk;
      req.data_out_pin <= mdo;
      req.read_data    <= rd;
      do @(posedge clock); while (!req.ready);
      board.note_sample(clk, mdo, rd);
      sent_count++;
   endtask

   // one management clock period; extra samples around the edge when stretched
   task automatic send_bit(input logic mdo, input logic [15:0] rd, input bit stretch);
      int lows;
      int highs;
      lows  = stretch ? 1 + ($urandom_range(0, 3) == 0) : 1;
      highs = stretch ? 1 + ($urandom_range(0, 3) == 0) : 1;
      repeat (lows) send_sample(1'b0, mdo, 16'($urandom_range(0, 65535)));
      send_sample(1'b1, mdo, rd);
      // data may wander once the edge has passed
      repeat (highs - 1)
         send_sample(1'b1, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
   endtask

   task automatic send_frame(input logic [1:0] op, input logic [15:0] rd,
                             input int preamble, input int cut);
      logic [31:0] bits;
      bits = {START_BITS, op, 10'($urandom_range(0, 1023)), 2'($urandom_range(0, 3)),
              16'($urandom_range(0, 65535))};
      repeat (preamble) send_bit(1'b1, 16'($urandom_range(0, 65535)), 1'b1);
      for (int i = FRAME_BITS - 1; i >= FRAME_BITS - cut; i--)
         send_bit(bits[i], rd, 1'b1);
   endtask

   initial begin
      int          kind;
      int          preamble;
      bit          needs_resync;
      logic [1:0]  op;
      logic [15:0] rd;

      reset            <= 1'b1;
      req.valid        <= 1'b0;
      req.clock_pin    <= 1'b1;
      req.data_out_pin <= 1'b1;
      req.read_data    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // levels held with no rising edge, read data at both extremes
      send_sample(1'b1, 1'b1, 16'hffff);
      send_sample(1'b1, 1'b0, 16'h0000);
      send_sample(1'b0, 1'b1, 16'hffff);
      send_sample(1'b0, 1'b0, 16'h0000);
      // second start bit low abandons the frame
      send_bit(1'b0, 16'hffff, 1'b0);
      send_bit(1'b0, 16'h0000, 1'b0);
      // opcode 00 then opcode 11
      send_bit(1'b0, 16'h0000, 1'b0);
      send_bit(1'b1, 16'h0000, 1'b0);
      send_bit(OPC_ZERO[1], 16'h0000, 1'b0);
      send_bit(OPC_ZERO[0], 16'h0000, 1'b0);
      send_bit(1'b0, 16'hffff, 1'b0);
      send_bit(1'b1, 16'hffff, 1'b0);
      send_bit(OPC_ONES[1], 16'hffff, 1'b0);
      send_bit(OPC_ONES[0], 16'hffff, 1'b0);

      needs_resync = 1'b0;
      while (sent_count < SAMPLE_TARGET) begin
         kind     = $urandom_range(0, 9);
         preamble = needs_resync ? RESYNC_BITS : $urandom_range(0, 3);
         op       = $urandom_range(0, 1) ? OPC_READ : OPC_WRITE;
         case ($urandom_range(0, 2))
            0: rd = 16'h0000;
            1: rd = 16'hffff;
            default: rd = 16'($urandom_range(0, 65535));
         endcase
         if (kind < 7) begin
            send_frame(op, rd, preamble, FRAME_BITS);
            needs_resync = 1'b0;
         end else if (kind == 7) begin
            if ($urandom_range(0, 2) == 0) begin
               repeat (preamble) send_bit(1'b1, rd, 1'b1);
               send_bit(1'b0, rd, 1'b1);
               send_bit(1'b0, rd, 1'b1);
            end else begin
               send_frame($urandom_range(0, 1) ? OPC_ZERO : OPC_ONES, rd, preamble, 4);
            end
            needs_resync = 1'b0;
         end else if (kind == 8) begin
            send_frame(op, rd, preamble, $urandom_range(5, FRAME_BITS - 1));
            needs_resync = 1'b1;
         end else begin
            repeat ($urandom_range(3, 20))
               send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           16'($urandom_range(0, 65535)));
            needs_resync = 1'b1;
         end
      end
      req.valid <= 1'b0;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.mismatch_count == 0 && board.pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int         stall;
      result_type got;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         // long hold-off so the block fills up and stalls its input
         if (!hold_done && board.checked_count >= HOLD_AFTER) begin
            hold_done   = 1'b1;
            hold_active = 1'b1;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active = 1'b0;
         end
         stall = draw_wait();
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         got.data_in_pin  = rsp.data_in_pin;
         got.phy_address  = rsp.phy_address;
         got.reg_address  = rsp.reg_address;
         got.read_strobe  = rsp.read_strobe;
         got.write_strobe = rsp.write_strobe;
         got.write_value  = rsp.write_value;
         got.bad_opcode   = rsp.bad_opcode;
         board.check_result(got);
      end
   end

endmodule
